// File: sv/rssc_pkg.sv
package rssc_pkg;

  localparam int unsigned SeqW    = 7;
  localparam int unsigned CountW  = 16;
  localparam int unsigned BytesW  = 32;
  localparam int unsigned ByteW   = 8;

  // Largest slot width (header included) that is still taken as a packet
  localparam logic [ByteW-1:0] MaxPayload = 8'd32;
  localparam int unsigned      ContBit    = 7;

  // Stream packing widths
  localparam int unsigned InDataW  = 2 * ByteW;
  localparam int unsigned OutDataW = ByteW + 2 * CountW + BytesW;
  localparam int unsigned OutUserW = 3;

  typedef enum logic {
    FUNC_HEADER  = 1'b0,
    FUNC_PAYLOAD = 1'b1
  } func_e;

  typedef struct packed {
    func_e             func;
    logic [ByteW-1:0]  slot_width;
    logic [ByteW-1:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic               out_valid;
    logic [ByteW-1:0]   out_byte;
    logic               discard_partial;
    logic               flush_request;
    logic [CountW-1:0]  lost_total;
    logic [CountW-1:0]  packet_total;
    logic [BytesW-1:0]  byte_total;
  } result_t;

endpackage

// File: sv/rssc_in_reg.sv
module rssc_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rssc_pkg::item_t item_i,
  input  logic           adv_i,
  output logic           valid_o,
  output rssc_pkg::item_t item_o
);
  import rssc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // Stage is free when empty or when its item moves on this cycle
  assign ready_o = !valid_q || adv_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: sv/rssc_core.sv
module rssc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  rssc_pkg::item_t   item_i,
  output rssc_pkg::result_t res_o
);
  import rssc_pkg::*;

  typedef enum logic [1:0] {
    MODE_IGNORE = 2'd0,
    MODE_PASS   = 2'd1,
    MODE_DROP   = 2'd2
  } mode_e;

  logic [SeqW-1:0]   last_seq_q, last_seq_d;
  mode_e             mode_q, mode_d;
  logic [CountW-1:0] lost_q, lost_d;
  logic [CountW-1:0] pkt_q, pkt_d;
  logic [BytesW-1:0] bytes_q, bytes_d;

  logic              is_hdr, width_zero, oversize, hdr_ok;
  logic [SeqW-1:0]   seq_exp, seq_recv, seq_gap;
  logic              seq_match;
  logic [CountW:0]   lost_sum, pkt_sum;
  logic [BytesW:0]   bytes_sum;
  logic              pass_byte;

  assign is_hdr     = (item_i.func == FUNC_HEADER);
  assign width_zero = (item_i.slot_width == '0);
  assign oversize   = (item_i.slot_width > MaxPayload);
  assign hdr_ok     = is_hdr && !width_zero && !oversize;

  assign seq_exp   = last_seq_q + SeqW'(1);
  assign seq_recv  = item_i.data_byte[SeqW-1:0];
  assign seq_gap   = seq_recv - seq_exp;
  assign seq_match = (seq_recv == seq_exp);

  assign lost_sum  = {1'b0, lost_q} + (CountW+1)'(seq_gap);
  assign pkt_sum   = {1'b0, pkt_q} + (CountW+1)'(1);
  assign bytes_sum = {1'b0, bytes_q} + (BytesW+1)'(item_i.slot_width);

  assign pass_byte = !is_hdr && (mode_q == MODE_PASS);

  always_comb begin
    last_seq_d = last_seq_q;
    mode_d     = mode_q;
    lost_d     = lost_q;
    pkt_d      = pkt_q;
    bytes_d    = bytes_q;
    if (is_hdr) begin
      if (!hdr_ok) begin
        mode_d = MODE_IGNORE;
      end else begin
        pkt_d      = pkt_sum[CountW] ? '1 : pkt_sum[CountW-1:0];
        bytes_d    = bytes_sum[BytesW] ? '1 : bytes_sum[BytesW-1:0];
        last_seq_d = seq_recv;
        if (seq_match) begin
          mode_d = MODE_PASS;
        end else begin
          lost_d = lost_sum[CountW] ? '1 : lost_sum[CountW-1:0];
          mode_d = item_i.data_byte[ContBit] ? MODE_DROP : MODE_PASS;
        end
      end
    end else if (mode_q == MODE_DROP && item_i.data_byte == '0) begin
      // zero byte closes the dropped tail of the broken frame
      mode_d = MODE_PASS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q <= '0;
      mode_q     <= MODE_IGNORE;
      lost_q     <= '0;
      pkt_q      <= '0;
      bytes_q    <= '0;
    end else if (fire_i) begin
      last_seq_q <= last_seq_d;
      mode_q     <= mode_d;
      lost_q     <= lost_d;
      pkt_q      <= pkt_d;
      bytes_q    <= bytes_d;
    end
  end

  always_comb begin
    res_o.out_valid       = pass_byte;
    res_o.out_byte        = pass_byte ? item_i.data_byte : '0;
    res_o.discard_partial = hdr_ok && !seq_match;
    res_o.flush_request   = is_hdr && oversize;
    res_o.lost_total      = lost_d;
    res_o.packet_total    = pkt_d;
    res_o.byte_total      = bytes_d;
  end

endmodule

// File: sv/rssc_out_reg.sv
module rssc_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  rssc_pkg::result_t res_i,
  output logic             valid_o,
  input  logic             ready_i,
  output rssc_pkg::result_t res_o
);
  import rssc_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: sv/radio_slot_sequence_checker_unit.sv
// Radio slot sequence checker. Takes one transfer per clock unless stalled,
// and returns exactly one result transfer for each input transfer, in
// order. Items pass an input register, then a result register; the per-item
// logic and the sequence/counter state update sit between them, so a header
// and the payload byte right behind it need no gap. s_axis_tready follows
// m_axis_tready combinationally when both registers hold data.
module radio_slot_sequence_checker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] slot_width, [15:8] data_byte
  input  logic [rssc_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] func
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] out_byte, [23:8] lost_total, [39:24] packet_total, [71:40] byte_total
  output logic [rssc_pkg::OutDataW-1:0] m_axis_tdata,
  // [0] out_valid, [1] discard_partial, [2] flush_request
  output logic [rssc_pkg::OutUserW-1:0] m_axis_tuser
);
  import rssc_pkg::*;

  item_t   in_item, st_item;
  logic    st_valid, out_ready, adv;
  result_t core_res, out_res;

  always_comb begin
    in_item.func       = func_e'(s_axis_tuser);
    in_item.slot_width = s_axis_tdata[ByteW-1:0];
    in_item.data_byte  = s_axis_tdata[2*ByteW-1:ByteW];
  end

  assign adv = st_valid && out_ready;

  rssc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .adv_i   (adv),
    .valid_o (st_valid),
    .item_o  (st_item)
  );

  rssc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (adv),
    .item_i (st_item),
    .res_o  (core_res)
  );

  rssc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (st_valid),
    .ready_o (out_ready),
    .res_i   (core_res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {out_res.byte_total, out_res.packet_total,
                         out_res.lost_total, out_res.out_byte};
  assign m_axis_tuser = {out_res.flush_request, out_res.discard_partial,
                         out_res.out_valid};

endmodule

// File: sv/rssc_checker.sv
module rssc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rssc_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [rssc_pkg::OutUserW-1:0] m_axis_tuser
);
  import rssc_pkg::*;

  logic out_xfer;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // a flushed header carries no byte and no discard
  a_flush_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && m_axis_tuser[2] |-> !m_axis_tuser[0] && !m_axis_tuser[1])
    else $error("flush_request together with byte or discard");

  a_discard_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("discard_partial on a forwarded byte");

  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !m_axis_tuser[0] |-> m_axis_tdata[ByteW-1:0] == '0)
    else $error("out_byte nonzero without out_valid");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind radio_slot_sequence_checker_unit rssc_checker u_rssc_checker (.*);

// File: bench/radio_slot_result_checker.sv
module radio_slot_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  // [7:0] slot_width, [15:8] data_byte
  input  logic [rssc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] func
  input  logic                          s_axis_tuser_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  // [7:0] out_byte, [23:8] lost_total, [39:24] packet_total, [71:40] byte_total
  input  logic [rssc_pkg::OutDataW-1:0] m_axis_tdata_i,
  // [0] out_valid, [1] discard_partial, [2] flush_request
  input  logic [rssc_pkg::OutUserW-1:0] m_axis_tuser_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import rssc_pkg::*;

  typedef enum logic [1:0] {
    MODE_IGNORE,
    MODE_PASS,
    MODE_DROP
  } slot_mode_e;

  logic [SeqW-1:0]   seq_q;
  slot_mode_e        mode_q;
  logic [CountW-1:0] lost_q;
  logic [CountW-1:0] packets_q;
  logic [BytesW-1:0] bytes_q;

  result_t slot_result_q[$];
  int      mismatches;
  int      results_seen;

  assign fail_count_o = mismatches;
  assign pending_o    = slot_result_q.size();

  // Advances the slot state by one item and returns the outcome it causes.
  task automatic apply_item(input item_t it, output result_t res);
    logic [SeqW-1:0]   recv;
    logic [SeqW-1:0]   gap;
    logic [CountW:0]   lost_sum;
    logic [BytesW:0]   byte_sum;
    res  = '0;
    recv = it.data_byte[SeqW-1:0];
    if (it.func == FUNC_HEADER) begin
      if (it.slot_width == '0) begin
        mode_q = MODE_IGNORE;
      end else if (it.slot_width > MaxPayload) begin
        res.flush_request = 1'b1;
        mode_q = MODE_IGNORE;
      end else begin
        if (packets_q != '1) packets_q = packets_q + CountW'(1);
        byte_sum = {1'b0, bytes_q} + (BytesW+1)'(it.slot_width);
        bytes_q  = byte_sum[BytesW] ? '1 : byte_sum[BytesW-1:0];
        seq_q    = seq_q + SeqW'(1);
        if (recv == seq_q) begin
          mode_q = MODE_PASS;
        end else begin
          gap      = recv - seq_q;
          lost_sum = {1'b0, lost_q} + (CountW+1)'(gap);
          lost_q   = lost_sum[CountW] ? '1 : lost_sum[CountW-1:0];
          res.discard_partial = 1'b1;
          seq_q  = recv;
          mode_q = it.data_byte[ContBit] ? MODE_DROP : MODE_PASS;
        end
      end
    end else begin
      if (mode_q == MODE_PASS) begin
        res.out_valid = 1'b1;
        res.out_byte  = it.data_byte;
      end else if (mode_q == MODE_DROP && it.data_byte == '0) begin
        mode_q = MODE_PASS;
      end
    end
    res.lost_total   = lost_q;
    res.packet_total = packets_q;
    res.byte_total   = bytes_q;
  endtask

  task automatic report(input string what, input result_t exp, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at result %0d", what, results_seen);
      $display("  expected: vld=%0b byte=%02h disc=%0b flush=%0b lost=%0d pkt=%0d bytes=%0d",
               exp.out_valid, exp.out_byte, exp.discard_partial, exp.flush_request,
               exp.lost_total, exp.packet_total, exp.byte_total);
      $display("  actual:   vld=%0b byte=%02h disc=%0b flush=%0b lost=%0d pkt=%0d bytes=%0d",
               got.out_valid, got.out_byte, got.discard_partial, got.flush_request,
               got.lost_total, got.packet_total, got.byte_total);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   it;
    result_t exp;
    result_t got;
    if (!rst_ni) begin
      seq_q     = '0;
      mode_q    = MODE_IGNORE;
      lost_q    = '0;
      packets_q = '0;
      bytes_q   = '0;
      slot_result_q.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.out_valid       = m_axis_tuser_i[0];
        got.discard_partial = m_axis_tuser_i[1];
        got.flush_request   = m_axis_tuser_i[2];
        got.out_byte        = m_axis_tdata_i[7:0];
        got.lost_total      = m_axis_tdata_i[23:8];
        got.packet_total    = m_axis_tdata_i[39:24];
        got.byte_total      = m_axis_tdata_i[71:40];
        if (slot_result_q.size() == 0) begin
          report("unexpected result transfer", '0, got);
        end else begin
          exp = slot_result_q.pop_front();
          if (got.out_valid !== exp.out_valid || got.out_byte !== exp.out_byte ||
              got.discard_partial !== exp.discard_partial ||
              got.flush_request !== exp.flush_request ||
              got.lost_total !== exp.lost_total || got.packet_total !== exp.packet_total ||
              got.byte_total !== exp.byte_total)
            report("result mismatch", exp, got);
        end
        results_seen++;
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        it.func       = func_e'(s_axis_tuser_i);
        it.slot_width = s_axis_tdata_i[7:0];
        it.data_byte  = s_axis_tdata_i[15:8];
        apply_item(it, exp);
        slot_result_q.push_back(exp);
      end
    end
  end

endmodule

// File: bench/tb_radio_slot_sequence_checker_unit.sv
module tb_radio_slot_sequence_checker_unit;
  import rssc_pkg::*;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  int fail_count;
  int pending;

  int unsigned     items_sent = 0;
  int unsigned     tx_gap_max = 8;
  int unsigned     rx_stall_max = 8;
  logic [SeqW-1:0] track_seq = '0;

  always #5 clk_i = ~clk_i;

  radio_slot_sequence_checker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  radio_slot_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input func_e f, input logic [7:0] w, input logic [7:0] d);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {d, w};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    // keep a copy of the sequence so most random headers can follow it
    if (f == FUNC_HEADER && w != 0 && w <= MaxPayload) track_seq = d[SeqW-1:0];
    items_sent++;
    if (items_sent % 80 == 0) tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
  endtask

  task automatic send_slot();
    logic [7:0]      w;
    logic [SeqW-1:0] seq;
    logic [7:0]      b;
    int unsigned     nbytes;
    int unsigned     r;
    r = $urandom_range(0, 19);
    if (r == 0) w = 8'd0;
    else if (r == 1) w = 8'($urandom_range(MaxPayload + 1, 255));
    else if (r < 10) w = 8'($urandom_range(1, 6));
    else w = 8'($urandom_range(1, MaxPayload));
    seq = ($urandom_range(0, 3) != 0) ? track_seq + SeqW'(1) : SeqW'($urandom);
    send_item(FUNC_HEADER, w, {1'($urandom), seq});
    if (w == 0 || w > MaxPayload) nbytes = $urandom_range(0, 3);
    else if ($urandom_range(0, 5) == 0) nbytes = $urandom_range(0, w + 2);
    else nbytes = 32'(w) - 1;
    repeat (nbytes) begin
      b = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom);
      send_item(FUNC_PAYLOAD, 8'($urandom), b);
    end
  endtask

  task automatic send_random_until(input int unsigned count);
    while (items_sent < count) begin
      if ($urandom_range(0, 9) == 0)
        send_item(func_e'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
      else
        send_slot();
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_item(FUNC_HEADER,  8'd0,   8'h81);  // empty slot
    send_item(FUNC_PAYLOAD, 8'd7,   8'hAA);  // ignored
    send_item(FUNC_HEADER,  8'd33,  8'h01);  // just too wide
    send_item(FUNC_HEADER,  8'd255, 8'hFF);
    send_item(FUNC_PAYLOAD, 8'd0,   8'h55);
    send_item(FUNC_HEADER,  8'd32,  8'h01);  // widest accepted, in sequence
    send_item(FUNC_PAYLOAD, 8'hFF,  8'h00);
    send_item(FUNC_PAYLOAD, 8'h00,  8'hFF);
    send_item(FUNC_HEADER,  8'd1,   8'h02);
    send_item(FUNC_HEADER,  8'd5,   8'h7F);  // gap, no continuation
    send_item(FUNC_PAYLOAD, 8'h12,  8'h80);
    send_item(FUNC_HEADER,  8'd4,   8'h00);  // sequence wraps
    send_item(FUNC_HEADER,  8'd6,   8'h85);  // gap with continuation
    send_item(FUNC_PAYLOAD, 8'h34,  8'h11);
    send_item(FUNC_PAYLOAD, 8'h56,  8'h00);  // zero ends the drop
    send_item(FUNC_PAYLOAD, 8'h78,  8'h22);
    send_item(FUNC_HEADER,  8'd3,   8'h86);  // continuation but in sequence
    send_item(FUNC_PAYLOAD, 8'h9A,  8'h00);
    send_item(FUNC_HEADER,  8'd2,   8'h90);
    send_item(FUNC_PAYLOAD, 8'hBC,  8'h01);
    send_item(FUNC_PAYLOAD, 8'hDE,  8'h01);  // beyond the announced width
    send_item(FUNC_PAYLOAD, 8'hF0,  8'h00);
    send_item(FUNC_PAYLOAD, 8'h0F,  8'h33);

    send_random_until(700);
    // repeating the last sequence loses 127 each time: drives lost count to saturation
    repeat (530) begin
      send_item(FUNC_HEADER, 8'($urandom_range(1, MaxPayload)), {1'($urandom), track_seq});
      if ($urandom_range(0, 7) == 0) send_item(FUNC_PAYLOAD, 8'($urandom), 8'($urandom));
    end
    send_random_until(1650);
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_radio_slot_sequence_checker_unit passed");
    end else begin
      $display("tb_radio_slot_sequence_checker_unit failed");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
      taken++;
      if (taken % 64 == 0) rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      // long hold-off so the block backs up and stalls its input
      if (taken == 200 || taken == 1300) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end
    end
  end

  initial begin
    #5000000;
    $display("tb_radio_slot_sequence_checker_unit failed");
    $finish;
  end

endmodule
